// File: hw/rtl/mesm_pkg.sv
// Shared types, field widths and codes of the modem expect-string matcher.
package mesm_pkg;

    // Default sizes of the pattern store.
    localparam int MAX_TRIGGERS_DEF = 8;
    localparam int PATTERN_LEN_DEF  = 32;

    // At most this many trigger results are reported for one received byte.
    localparam int RESULT_CAP = 8;
    localparam int CAP_W      = $clog2(RESULT_CAP);

    // Field widths of the request and result channels.
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int SEL_W    = 4;
    localparam int CPOS_W   = 5;
    localparam int TICKS_W  = 16;
    localparam int EVENT_W  = 2;
    localparam int TIDX_W   = 3;
    localparam int TCOUNT_W = 4;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_WRITE = 2'd3
    } kind_t;

    // Result events.
    typedef enum logic [EVENT_W-1:0] {
        EV_TRIGGER = 2'd0,
        EV_SUCCESS = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic do_start;
        logic do_write;
        logic do_tick;
        logic scan_init;
        logic scan_run;
        logic emit_one;
        logic emit_hit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  waiting;
        logic  tmo_zero;
        logic  tick_expire;
        logic  wait_hit;
        logic  scan_last;
        logic  hits_any;
        logic  emit_last;
        logic  out_free;
    } sts_t;

endpackage

// File: hw/rtl/mesm_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module mesm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 288
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // One write port and two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: hw/rtl/mesm_datapath.sv
// Datapath of the expect-string matcher: pattern store, progress, countdown and result register.
module mesm_datapath #(
    parameter int MAX_TRIGGERS = mesm_pkg::MAX_TRIGGERS_DEF,
    parameter int PATTERN_LEN  = mesm_pkg::PATTERN_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mesm_pkg::cmd_t                cmd,
    output mesm_pkg::sts_t                sts,
    input  logic                          cfg_wr,
    input  logic [mesm_pkg::TCOUNT_W-1:0] cfg_data,
    input  logic [mesm_pkg::KIND_W-1:0]   s_kind,
    input  logic [mesm_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [mesm_pkg::SEL_W-1:0]    s_pattern_select,
    input  logic [mesm_pkg::CPOS_W-1:0]   s_char_position,
    input  logic [mesm_pkg::TICKS_W-1:0]  s_timeout_ticks,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mesm_pkg::EVENT_W-1:0]  m_event_res,
    output logic [mesm_pkg::TIDX_W-1:0]   m_trigger_index,
    output logic                          m_last
);

    import mesm_pkg::*;

    localparam int NUM_PAT = MAX_TRIGGERS + 1;
    localparam int DEPTH   = NUM_PAT * PATTERN_LEN;
    localparam int AW      = $clog2(DEPTH);
    localparam int PW      = $clog2(NUM_PAT);
    localparam int GW      = $clog2(PATTERN_LEN + 1);
    localparam int HW      = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;

    // Latched request.
    kind_t                kind_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [SEL_W-1:0]     sel_reg;
    logic [CPOS_W-1:0]    cpos_reg;
    logic [TICKS_W-1:0]   tmo_reg;

    // Matcher state.
    logic [TCOUNT_W-1:0]  tcount_reg;
    logic                 waiting_reg;
    logic [TICKS_W-1:0]   ticks_reg;
    event_t               single_ev_reg;
    logic [GW-1:0]        progress_reg [NUM_PAT];

    // Scan pipeline: issue stage reads the store, check stage compares.
    logic [PW-1:0]        scan_ptr_reg;
    logic                 issue_done_reg;
    logic [PW-1:0]        chk_ptr_reg;
    logic                 chk_vld_reg;
    logic [GW-1:0]        chk_pos_reg;

    // Completed triggers of the current byte and results sent so far.
    logic [MAX_TRIGGERS-1:0] hits_reg;
    logic [CAP_W-1:0]        emit_cnt_reg;

    // Result register.
    logic                 m_valid_reg;
    event_t               m_event_reg;
    logic [TIDX_W-1:0]    m_tidx_reg;
    logic                 m_last_reg;

    logic [PW-1:0]        ntrig;
    logic [GW-1:0]        issue_pos;
    logic [AW-1:0]        base_addr;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [BYTE_W-1:0]    rd_data_a;
    logic [BYTE_W-1:0]    rd_data_b;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 ch_ok;
    logic                 match;
    logic                 complete;
    logic [GW-1:0]        prog_next;
    logic                 chk_now;
    logic [HW-1:0]        hit_idx;
    logic [HW-1:0]        first_idx;
    logic [MAX_TRIGGERS-1:0] hits_next;
    logic                 out_free;
    logic                 emit_last;

    // Trigger count in use, clamped to the store size.
    always_comb begin
        if (int'(tcount_reg) > MAX_TRIGGERS) begin
            ntrig = PW'(MAX_TRIGGERS);
        end else begin
            ntrig = PW'(tcount_reg);
        end
    end

    // Store addresses of the current character and the one after it.
    assign issue_pos = progress_reg[scan_ptr_reg];
    assign base_addr = AW'(int'(scan_ptr_reg) * PATTERN_LEN);
    assign rd_addr_a = (int'(issue_pos) < PATTERN_LEN) ? base_addr + AW'(issue_pos) : base_addr;
    assign rd_addr_b = (int'(issue_pos) + 1 < PATTERN_LEN) ? rd_addr_a + AW'(1) : rd_addr_a;

    // Pattern writes outside the store are dropped.
    assign wr_en   = cmd.do_write && (int'(sel_reg) <= MAX_TRIGGERS)
                     && (int'(cpos_reg) < PATTERN_LEN);
    assign wr_addr = AW'(int'(sel_reg) * PATTERN_LEN + int'(cpos_reg));

    mesm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (byte_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Compare the received byte with the pattern character at the checked position.
    always_comb begin
        ch_ok = int'(chk_pos_reg) < PATTERN_LEN;
        match = (byte_reg != '0) && ch_ok && (rd_data_a != '0) && (rd_data_a == byte_reg);
        complete = match && ((int'(chk_pos_reg) + 1 >= PATTERN_LEN) || (rd_data_b == '0));
        prog_next = match ? chk_pos_reg + GW'(1) : '0;
    end

    assign chk_now = cmd.scan_run && chk_vld_reg;
    assign hit_idx = HW'(int'(chk_ptr_reg) - 1);

    // Lowest pending trigger and the set left once it is sent.
    always_comb begin
        first_idx = '0;
        for (int i = MAX_TRIGGERS - 1; i >= 0; i--) begin
            if (hits_reg[i]) begin
                first_idx = HW'(i);
            end
        end
        hits_next = hits_reg;
        hits_next[first_idx] = 1'b0;
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_last = (hits_next == '0) || (emit_cnt_reg == CAP_W'(RESULT_CAP - 1));

    // Status toward the controller.
    always_comb begin
        sts.kind        = kind_reg;
        sts.waiting     = waiting_reg;
        sts.tmo_zero    = (tmo_reg == '0);
        sts.tick_expire = (ticks_reg <= TICKS_W'(1));
        sts.wait_hit    = chk_now && (chk_ptr_reg == '0) && complete;
        sts.scan_last   = chk_now && (chk_ptr_reg == ntrig);
        sts.hits_any    = |hits_reg;
        sts.emit_last   = emit_last;
        sts.out_free    = out_free;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcount_reg     <= '0;
            waiting_reg    <= 1'b0;
            ticks_reg      <= '0;
            for (int p = 0; p < NUM_PAT; p++) begin
                progress_reg[p] <= '0;
            end
            scan_ptr_reg   <= '0;
            issue_done_reg <= 1'b0;
            chk_ptr_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            hits_reg       <= '0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                tcount_reg <= cfg_data;
            end

            // A start clears all progress and arms the countdown unless the timeout is zero.
            if (cmd.do_start) begin
                for (int p = 0; p < NUM_PAT; p++) begin
                    progress_reg[p] <= '0;
                end
                if (tmo_reg == '0) begin
                    waiting_reg <= 1'b0;
                    ticks_reg   <= '0;
                end else begin
                    waiting_reg <= 1'b1;
                    ticks_reg   <= tmo_reg;
                end
            end

            if (cmd.do_tick) begin
                ticks_reg <= ticks_reg - TICKS_W'(1);
                if (ticks_reg <= TICKS_W'(1)) begin
                    waiting_reg <= 1'b0;
                end
            end

            if (cmd.scan_init) begin
                scan_ptr_reg   <= '0;
                issue_done_reg <= 1'b0;
                chk_vld_reg    <= 1'b0;
                hits_reg       <= '0;
                emit_cnt_reg   <= '0;
            end

            // Issue one pattern per cycle and check the one issued before.
            if (cmd.scan_run) begin
                chk_ptr_reg <= scan_ptr_reg;
                chk_vld_reg <= !issue_done_reg;
                if (scan_ptr_reg == ntrig) begin
                    issue_done_reg <= 1'b1;
                end else begin
                    scan_ptr_reg <= scan_ptr_reg + PW'(1);
                end
                if (chk_vld_reg) begin
                    progress_reg[chk_ptr_reg] <= prog_next;
                    if (complete) begin
                        if (chk_ptr_reg == '0) begin
                            waiting_reg <= 1'b0;
                        end else begin
                            hits_reg[hit_idx] <= 1'b1;
                        end
                    end
                end
            end

            // Result register.
            if (cmd.emit_one) begin
                m_valid_reg <= 1'b1;
            end else if (cmd.emit_hit) begin
                m_valid_reg  <= 1'b1;
                hits_reg     <= hits_next;
                emit_cnt_reg <= emit_cnt_reg + CAP_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= kind_t'(s_kind);
            byte_reg <= s_data_byte;
            sel_reg  <= s_pattern_select;
            cpos_reg <= s_char_position;
            tmo_reg  <= s_timeout_ticks;
        end
        if (cmd.do_start || cmd.do_tick) begin
            single_ev_reg <= EV_TIMEOUT;
        end else if (chk_now && complete && (chk_ptr_reg == '0)) begin
            single_ev_reg <= EV_SUCCESS;
        end
        if (cmd.scan_run) begin
            chk_pos_reg <= issue_pos;
        end
        if (cmd.emit_one) begin
            m_event_reg <= single_ev_reg;
            m_tidx_reg  <= '0;
            m_last_reg  <= 1'b1;
        end else if (cmd.emit_hit) begin
            m_event_reg <= EV_TRIGGER;
            m_tidx_reg  <= TIDX_W'(first_idx);
            m_last_reg  <= emit_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = m_event_reg;
    assign m_trigger_index = m_tidx_reg;
    assign m_last          = m_last_reg;

    // A result is loaded only when the result register can take it.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_one || cmd.emit_hit) |-> (!m_valid_reg || m_ready))
        else $error("result loaded while the result register is occupied");

    // A running wait always has time left on its countdown.
    a_wait_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> (ticks_reg != '0))
        else $error("waiting with an expired countdown");

    // The check stage never looks past the triggers in use.
    a_chk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_now |-> (chk_ptr_reg <= ntrig))
        else $error("pattern checked beyond the trigger count");

endmodule

// File: hw/rtl/mesm_ctrl.sv
// Controller state machine of the expect-string matcher.
module mesm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mesm_pkg::sts_t sts,
    output mesm_pkg::cmd_t cmd
);

    import mesm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT_ONE,
        ST_EMIT_HITS
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (sts.kind)
                    KIND_START: begin
                        cmd.do_start = 1'b1;
                        state_next   = sts.tmo_zero ? ST_EMIT_ONE : ST_IDLE;
                    end
                    KIND_WRITE: begin
                        cmd.do_write = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    KIND_TICK: begin
                        if (sts.waiting) begin
                            cmd.do_tick = 1'b1;
                            state_next  = sts.tick_expire ? ST_EMIT_ONE : ST_IDLE;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_BYTE: begin
                        if (sts.waiting) begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.wait_hit) begin
                    state_next = ST_EMIT_ONE;
                end else if (sts.scan_last) begin
                    state_next = ST_EMIT_HITS;
                end
            end
            ST_EMIT_ONE: begin
                if (sts.out_free) begin
                    cmd.emit_one = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_HITS: begin
                if (!sts.hits_any) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit_hit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A completed wait pattern ends the scan and reports success next.
    a_wait_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && sts.wait_hit) |=> (state_reg == ST_EMIT_ONE))
        else $error("wait pattern match did not end the scan");

    // Bytes are only scanned while a wait is running.
    a_scan_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_run |-> sts.waiting)
        else $error("scan running outside a wait");

endmodule

// File: hw/rtl/modem_expect_string_matcher.sv
// Top level of the modem expect-string matcher.
// A received byte is scanned against the wait pattern and the triggers in use, one pattern per
// cycle, then the completed triggers are reported; a wait match ends the scan and reports success.
// A start with a zero timeout, or a tick that ends the countdown, reports a timeout.
// Result stalls add cycles; one request at a time. Reset (aresetn, synchronous, active low)
// clears progress, countdown, trigger_count and handshakes; the store must be written first.
module modem_expect_string_matcher #(
    parameter int MAX_TRIGGERS = mesm_pkg::MAX_TRIGGERS_DEF,
    parameter int PATTERN_LEN  = mesm_pkg::PATTERN_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mesm_pkg::KIND_W-1:0]   s_kind,
    input  logic [mesm_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [mesm_pkg::SEL_W-1:0]    s_pattern_select,
    input  logic [mesm_pkg::CPOS_W-1:0]   s_char_position,
    input  logic [mesm_pkg::TICKS_W-1:0]  s_timeout_ticks,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mesm_pkg::EVENT_W-1:0]  m_event_res,
    output logic [mesm_pkg::TIDX_W-1:0]   m_trigger_index,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mesm_pkg::TCOUNT_W-1:0] cfg_data
);

    import mesm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The trigger count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    mesm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mesm_datapath #(
        .MAX_TRIGGERS (MAX_TRIGGERS),
        .PATTERN_LEN  (PATTERN_LEN)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .s_kind           (s_kind),
        .s_data_byte      (s_data_byte),
        .s_pattern_select (s_pattern_select),
        .s_char_position  (s_char_position),
        .s_timeout_ticks  (s_timeout_ticks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_trigger_index  (m_trigger_index),
        .m_last           (m_last)
    );

endmodule

// File: tb/tb_modem_expect_string_matcher.sv
// Self-checking testbench for the modem expect-string matcher: predicts and checks every result.
module tb_modem_expect_string_matcher;
    import mesm_pkg::*;

    localparam int NUM_TRIG = MAX_TRIGGERS_DEF;
    localparam int PAT_LEN  = PATTERN_LEN_DEF;
    // Cycles to let the block settle once every expected result has come back.
    localparam int SETTLE   = 40;
    // Trigger counts used by the random phases; phase 4 draws its own value.
    localparam logic [TCOUNT_W-1:0] PHASE_COUNTS [7] =
        '{4'd8, 4'd15, 4'd0, 4'd3, 4'd9, 4'd1, 4'd8};

    // One expected result.
    typedef struct {
        event_t              ev;
        logic [TIDX_W-1:0]   idx;
        logic                last;
    } outcome_t;

    // Tracks the matcher state, predicts its results and checks the ones that arrive.
    class match_tracker;
        logic [BYTE_W-1:0]   store [NUM_TRIG+1][PAT_LEN];
        int unsigned         progress [NUM_TRIG+1];
        bit                  waiting;
        logic [TICKS_W-1:0]  ticks_left;
        logic [TCOUNT_W-1:0] trigger_count;
        int unsigned         live_requests;
        int unsigned         errors;
        outcome_t            awaited [$];

        function void push_outcome(event_t ev, logic [TIDX_W-1:0] idx, logic last);
            outcome_t o;
            o.ev = ev;
            o.idx = idx;
            o.last = last;
            awaited.push_back(o);
        endfunction

        // Step one pattern with a received byte; returns 1 when the pattern completes.
        function bit advance_pattern(int p, logic [BYTE_W-1:0] b);
            int unsigned at;
            logic [BYTE_W-1:0] ch;
            at = progress[p];
            ch = (at < PAT_LEN) ? store[p][at] : '0;
            if (b == '0 || ch == '0 || b != ch) begin
                progress[p] = 0;
                return 1'b0;
            end
            at++;
            progress[p] = at;
            if (at >= PAT_LEN) return 1'b1;
            return store[p][at] == '0;
        endfunction

        // Update the state for an accepted request and queue the results it causes.
        function void note_request(kind_t k, logic [BYTE_W-1:0] data, logic [SEL_W-1:0] sel,
                                   logic [CPOS_W-1:0] cpos, logic [TICKS_W-1:0] tmo);
            int limit;
            int hits;
            int t;
            limit = (trigger_count > NUM_TRIG) ? NUM_TRIG : int'(trigger_count);
            hits = 0;
            case (k)
                KIND_START: begin
                    live_requests++;
                    foreach (progress[i]) progress[i] = 0;
                    if (tmo == '0) begin
                        waiting = 1'b0;
                        ticks_left = '0;
                        push_outcome(EV_TIMEOUT, '0, 1'b1);
                    end else begin
                        waiting = 1'b1;
                        ticks_left = tmo;
                    end
                end
                KIND_WRITE: begin
                    // Selects beyond the last trigger are dropped by the block.
                    if (sel <= NUM_TRIG) begin
                        live_requests++;
                        store[sel][cpos] = data;
                    end
                end
                KIND_TICK: begin
                    if (waiting) begin
                        live_requests++;
                        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
                        if (ticks_left == '0) begin
                            waiting = 1'b0;
                            push_outcome(EV_TIMEOUT, '0, 1'b1);
                        end
                    end
                end
                KIND_BYTE: begin
                    if (waiting) begin
                        live_requests++;
                        // A wait pattern hit ends the wait before any trigger is looked at.
                        if (advance_pattern(0, data)) begin
                            waiting = 1'b0;
                            push_outcome(EV_SUCCESS, '0, 1'b1);
                        end else begin
                            for (t = 1; t <= limit; t++) begin
                                if (advance_pattern(t, data) && hits < RESULT_CAP) begin
                                    push_outcome(EV_TRIGGER, TIDX_W'(t - 1), 1'b0);
                                    hits++;
                                end
                            end
                            if (hits > 0) awaited[awaited.size() - 1].last = 1'b1;
                        end
                    end
                end
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Compare an accepted result with the oldest expectation.
        function void check_result(logic [EVENT_W-1:0] ev, logic [TIDX_W-1:0] idx, logic last);
            outcome_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: event %0d index %0d last %0d",
                         $time, ev, idx, last);
                return;
            end
            want = awaited.pop_front();
            if (ev !== want.ev) begin
                errors++;
                $display("%0t: event mismatch: expected %0d, actual %0d", $time, want.ev, ev);
            end
            if (idx !== want.idx) begin
                errors++;
                $display("%0t: trigger index mismatch: expected %0d, actual %0d",
                         $time, want.idx, idx);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last flag mismatch: expected %0d, actual %0d",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind;
    logic [BYTE_W-1:0]    s_data_byte;
    logic [SEL_W-1:0]     s_pattern_select;
    logic [CPOS_W-1:0]    s_char_position;
    logic [TICKS_W-1:0]   s_timeout_ticks;
    logic                 m_valid;
    logic                 m_ready;
    logic [EVENT_W-1:0]   m_event_res;
    logic [TIDX_W-1:0]    m_trigger_index;
    logic                 m_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TCOUNT_W-1:0]  cfg_data;

    match_tracker board = new();
    // Set for the final stretch, where neither side idles.
    bit calm = 1'b0;

    modem_expect_string_matcher uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_data_byte      (s_data_byte),
        .s_pattern_select (s_pattern_select),
        .s_char_position  (s_char_position),
        .s_timeout_ticks  (s_timeout_ticks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_trigger_index  (m_trigger_index),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    // Clock with a period of 12.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Character i of the full-slot trigger: 25 distinct letters, then "gfedcba".
    function automatic logic [BYTE_W-1:0] slot_char(int i);
        if (i < 19) return BYTE_W'(8'h68 + i);
        if (i < 25) return BYTE_W'(8'h48 + i - 19);
        return BYTE_W'(8'h67 - (i - 25));
    endfunction

    // Initial store contents: the wait pattern is "WXYZ", the last trigger fills its
    // slot, and trigger t holds the last t characters of that slot.
    function automatic logic [BYTE_W-1:0] init_char(int p, int c);
        if (p == 0) return (c < 4) ? BYTE_W'(8'h57 + c) : '0;
        if (p == NUM_TRIG) return slot_char(c);
        return (c < p) ? slot_char(PAT_LEN - p + c) : '0;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(kind_t k, logic [BYTE_W-1:0] data, logic [SEL_W-1:0] sel,
                                logic [CPOS_W-1:0] cpos, logic [TICKS_W-1:0] tmo);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_kind           <= k;
        s_data_byte      <= data;
        s_pattern_select <= sel;
        s_char_position  <= cpos;
        s_timeout_ticks  <= tmo;
        do @(posedge aclk); while (!s_ready);
        board.note_request(k, data, sel, cpos, tmo);
    endtask

    task automatic start_wait(logic [TICKS_W-1:0] tmo);
        send_request(KIND_START, BYTE_W'($urandom), SEL_W'($urandom), CPOS_W'($urandom), tmo);
    endtask

    task automatic feed_byte(logic [BYTE_W-1:0] b);
        send_request(KIND_BYTE, b, SEL_W'($urandom), CPOS_W'($urandom), TICKS_W'($urandom));
    endtask

    task automatic give_tick();
        send_request(KIND_TICK, BYTE_W'($urandom), SEL_W'($urandom), CPOS_W'($urandom),
                     TICKS_W'($urandom));
    endtask

    task automatic put_char(logic [SEL_W-1:0] sel, logic [CPOS_W-1:0] cpos,
                            logic [BYTE_W-1:0] ch);
        send_request(KIND_WRITE, ch, sel, cpos, TICKS_W'($urandom));
    endtask

    // Send the bytes of a stored pattern as it currently stands.
    task automatic feed_pattern(int p);
        int c;
        c = 0;
        while (c < PAT_LEN && board.store[p][c] != '0) begin
            feed_byte(board.store[p][c]);
            c++;
        end
    endtask

    // Replace a pattern with a short random one over the letters a to g.
    task automatic rewrite_pattern(int p, int len);
        int c;
        for (c = 0; c < len; c++) begin
            put_char(SEL_W'(p), CPOS_W'(c), BYTE_W'(8'h61 + $urandom_range(0, 6)));
        end
        put_char(SEL_W'(p), CPOS_W'(len), '0);
    endtask

    // Write the trigger count once all results are in and the block has gone quiet.
    task automatic set_trigger_count(logic [TCOUNT_W-1:0] v);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.trigger_count = v;
    endtask

    // Stimulus: store fill, directed cases, then random phases over several trigger counts.
    initial begin
        int unsigned quota;
        int unsigned pick;
        int phase;
        int p;
        int c;
        logic [TCOUNT_W-1:0] next_count;

        s_valid          <= 1'b0;
        s_kind           <= KIND_START;
        s_data_byte      <= '0;
        s_pattern_select <= '0;
        s_char_position  <= '0;
        s_timeout_ticks  <= '0;
        cfg_valid        <= 1'b0;
        cfg_data         <= '0;
        aresetn          <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Every pattern is written up to its terminator, or over its whole slot,
        // before any byte is matched; later writes never move a terminator past that.
        for (p = 0; p <= NUM_TRIG; p++) begin
            for (c = 0; c < PAT_LEN; c++) begin
                put_char(SEL_W'(p), CPOS_W'(c), init_char(p, c));
                if (init_char(p, c) == '0) break;
            end
        end
        set_trigger_count(4'd8);

        // Bytes and ticks are ignored while idle.
        feed_byte(8'h61);
        give_tick();
        // A zero timeout reports at once; then a long wait.
        start_wait('0);
        start_wait(16'hFFFF);
        // A zero byte clears progress; "gfedcba" then completes seven triggers together.
        feed_byte('0);
        for (c = 25; c < PAT_LEN; c++) feed_byte(slot_char(c));
        // Right after a match the next byte is a mismatch, even for a one-letter trigger.
        feed_byte(8'h61);
        feed_byte(8'hFF);
        // An emptied trigger never matches; the write happens during the wait.
        put_char(4'd3, 5'd0, '0);
        for (c = 29; c < PAT_LEN; c++) feed_byte(slot_char(c));
        // Restart, then count down to a timeout.
        start_wait(16'd2);
        give_tick();
        give_tick();
        // Writes outside the store are dropped.
        put_char(4'd15, 5'd31, 8'hFF);
        put_char(4'd9, 5'd0, 8'h61);
        // The wait pattern ends the wait.
        start_wait(16'd5);
        feed_pattern(0);

        for (phase = 0; phase < 7; phase++) begin
            next_count = (phase == 4) ? TCOUNT_W'($urandom_range(2, 7)) : PHASE_COUNTS[phase];
            set_trigger_count(next_count);
            if (phase == 6) calm = 1'b1;
            quota = board.live_requests + 1;
            while (board.live_requests < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // Well-formed: make sure a wait is running, then play a whole pattern.
                    if (!board.waiting) start_wait(TICKS_W'($urandom_range(3, 12)));
                    if ($urandom_range(0, 1) == 0) feed_byte('0);
                    feed_pattern(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, NUM_TRIG));
                end else if (pick < 55) begin
                    if ($urandom_range(0, 3) == 0) feed_byte(BYTE_W'($urandom));
                    else feed_byte(BYTE_W'(8'h61 + $urandom_range(0, 6)));
                end else if (pick < 65) begin
                    give_tick();
                end else if (pick < 75) begin
                    if ($urandom_range(0, 4) == 0) start_wait('0);
                    else if ($urandom_range(0, 4) == 0) start_wait(TICKS_W'($urandom));
                    else start_wait(TICKS_W'($urandom_range(1, 8)));
                end else if (pick < 85) begin
                    rewrite_pattern($urandom_range(0, NUM_TRIG - 1), $urandom_range(1, 3));
                end else begin
                    // A random write aimed past the last trigger, which the block drops.
                    put_char(SEL_W'($urandom_range(NUM_TRIG + 1, (1 << SEL_W) - 1)),
                             CPOS_W'($urandom), BYTE_W'($urandom));
                end
            end
        end

        // Drain and let the block settle before the verdict.
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: check each accepted result and stall in random bursts.
    initial begin
        int unsigned stall;
        stall = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) board.check_result(m_event_res, m_trigger_index, m_last);
            if (stall != 0) begin
                stall--;
                m_ready <= (stall == 0);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mesm_pkg.sv
hw/rtl/mesm_ram.sv
hw/rtl/mesm_datapath.sv
hw/rtl/mesm_ctrl.sv
hw/rtl/modem_expect_string_matcher.sv
tb/tb_modem_expect_string_matcher.sv
